@@ sv/widest_path_query_core_assert.svh @@
// Assertion macros shared by the widest-path query checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef WIDEST_PATH_QUERY_CORE_ASSERT_SVH
`define WIDEST_PATH_QUERY_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WPQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WPQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/wpq_pkg.sv @@
// Shared widths, constants and control structs of the widest-path query core.
// No dependencies; imported by the sequencer, the top level and the checker.
package wpq_pkg;

   localparam int MAX_NODES_DEF = 16;
   localparam int CAP_W         = 17;
   localparam int NODE_W        = 4;
   localparam int NC_W          = 5;

   localparam logic [NC_W-1:0]  NC_RESET        = 5'd16;
   localparam logic [CAP_W-1:0] CAP_MAX         = 17'd100000;
   localparam logic [CAP_W-1:0] SAME_NODE_WIDTH = 17'd100001;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic idle;
      logic clr_row;
      logic init_q;
      logic row_read;
      logic u_inc;
      logic u_clr;
      logic round_inc;
      logic sel_dst;
      logic emit;
      logic res_special;
   } ctrl_word_type;

   typedef struct packed {
      logic query_go;
      logic special;
      logic last_row;
      logic row_end;
      logic round_end;
   } status_type;

endpackage

@@ sv/wpq_sequencer.sv @@
// Microcoded sequencer: step counter, control ROM and conditional jumps.
// Depends on wpq_pkg for the control word and status structs.
module wpq_sequencer
   import wpq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  status_type    status,
   output ctrl_word_type ctrl
);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_CHECK, S_ROW, S_DRAIN, S_ROUND, S_FETCH, S_SPECIAL
   } step_type;

   typedef enum logic [2:0] {
      C_ALWAYS, C_QUERY, C_SPECIAL, C_LAST_ROW, C_ROW_END, C_ROUND_END
   } cond_type;

   typedef struct packed {
      ctrl_word_type ctrl;
      cond_type      cond;
      step_type      jump_t;
      step_type      jump_f;
   } rom_word_type;

   function automatic rom_word_type rom_read(input step_type step);
      rom_word_type w;
      w = '0;
      unique case (step)
         S_CLEAR: begin
            w.ctrl.clr_row = 1'b1;
            w.ctrl.u_inc   = 1'b1;
            w.cond         = C_LAST_ROW;
            w.jump_t       = S_IDLE;
            w.jump_f       = S_CLEAR;
         end
         S_IDLE: begin
            w.ctrl.idle = 1'b1;
            w.cond      = C_QUERY;
            w.jump_t    = S_CHECK;
            w.jump_f    = S_IDLE;
         end
         S_CHECK: begin
            w.ctrl.init_q = 1'b1;
            w.ctrl.u_clr  = 1'b1;
            w.cond        = C_SPECIAL;
            w.jump_t      = S_SPECIAL;
            w.jump_f      = S_ROW;
         end
         S_ROW: begin
            w.ctrl.row_read = 1'b1;
            w.ctrl.u_inc    = 1'b1;
            w.cond          = C_ROW_END;
            w.jump_t        = S_DRAIN;
            w.jump_f        = S_ROW;
         end
         S_DRAIN: begin
            w.cond   = C_ALWAYS;
            w.jump_t = S_ROUND;
            w.jump_f = S_ROUND;
         end
         S_ROUND: begin
            w.ctrl.round_inc = 1'b1;
            w.ctrl.u_clr     = 1'b1;
            w.cond           = C_ROUND_END;
            w.jump_t         = S_FETCH;
            w.jump_f         = S_ROW;
         end
         S_FETCH: begin
            w.ctrl.sel_dst = 1'b1;
            w.ctrl.emit    = 1'b1;
            w.cond         = C_ALWAYS;
            w.jump_t       = S_IDLE;
            w.jump_f       = S_IDLE;
         end
         S_SPECIAL: begin
            w.ctrl.emit        = 1'b1;
            w.ctrl.res_special = 1'b1;
            w.cond             = C_ALWAYS;
            w.jump_t           = S_IDLE;
            w.jump_f           = S_IDLE;
         end
      endcase
      return w;
   endfunction

   step_type     step_ff;
   step_type     step_in;
   rom_word_type word;
   logic         take;

   always_comb begin
      word = rom_read(step_ff);
      unique case (word.cond)
         C_ALWAYS:    take = 1'b1;
         C_QUERY:     take = status.query_go;
         C_SPECIAL:   take = status.special;
         C_LAST_ROW:  take = status.last_row;
         C_ROW_END:   take = status.row_end;
         C_ROUND_END: take = status.round_end;
         default:     take = 1'b0;
      endcase
      step_in = take ? word.jump_t : word.jump_f;
      ctrl    = word.ctrl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

@@ sv/widest_path_query_core.sv @@
// Widest-path query core: adjacency memory, relaxation lanes and result register.
// Depends on wpq_pkg and wpq_sequencer.
// A write beat is taken while idle and leaves busy low. A query runs R relaxation rounds to its
// result strobe, R <= n with n the active node count, one adjacency row read per
// cycle; endpoints out of use or equal answer without any relaxation round. Synchronous reset clears
// the adjacency memory one row a cycle, with busy high.
module widest_path_query_core
   import wpq_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_opcode,
   input  logic [NODE_W-1:0] req_from_node,
   input  logic [NODE_W-1:0] req_to_node,
   input  logic [CAP_W-1:0]  req_capacity,
   output logic              rsp_valid,
   output logic [CAP_W-1:0]  rsp_bottleneck,
   input  logic              csr_wr_en,
   input  logic [NC_W-1:0]   csr_wr_data
);

   localparam int NW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_NODES + 1);

   ctrl_word_type ctrl;
   status_type    status;

   logic [NC_W-1:0]   node_count_ff;
   logic [NW-1:0]     u_ff;
   logic [CW-1:0]     round_ff;
   logic              changed_ff;
   logic              rd_vld_ff;
   logic              rsp_valid_ff;
   logic [NODE_W-1:0] src_ff;
   logic [NODE_W-1:0] dst_ff;
   logic [CAP_W-1:0]  bu_ff;
   logic [CAP_W-1:0]  rsp_data_ff;
   logic [MAX_NODES-1:0][CAP_W-1:0] row_ff;
   logic [CAP_W-1:0]  best_ff [MAX_NODES];
   logic [MAX_NODES-1:0][CAP_W-1:0] adj_mem [MAX_NODES];

   logic [CW-1:0]     eff_n;
   logic              accept;
   logic              wr_ok;
   logic              out_range;
   logic [CAP_W-1:0]  cap_sat;
   logic [CAP_W-1:0]  special_val;
   logic [NW-1:0]     rd_idx;
   logic [CAP_W-1:0]  best_rd;
   logic [CAP_W-1:0]  cand [MAX_NODES];
   logic [MAX_NODES-1:0] upd;

   wpq_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   always_comb begin
      eff_n = (32'(node_count_ff) > MAX_NODES) ? CW'(MAX_NODES) : CW'(node_count_ff);
      busy = !ctrl.idle;
      accept = start && !busy;
      wr_ok = accept && (req_opcode == OP_WRITE) && (32'(req_from_node) < MAX_NODES)
         && (32'(req_to_node) < MAX_NODES);
      cap_sat = (req_capacity > CAP_MAX) ? CAP_MAX : req_capacity;
      out_range = (32'(src_ff) >= 32'(eff_n)) || (32'(dst_ff) >= 32'(eff_n));
      special_val = out_range ? '0 : SAME_NODE_WIDTH;
      rd_idx = ctrl.sel_dst ? NW'(dst_ff) : u_ff;
      best_rd = best_ff[rd_idx];
      for (int v = 0; v < MAX_NODES; v++) begin
         cand[v] = (row_ff[v] < bu_ff) ? row_ff[v] : bu_ff;
         upd[v] = rd_vld_ff && (32'(eff_n) > v) && (cand[v] > best_ff[v]);
      end
      status.query_go = start && (req_opcode == OP_QUERY);
      status.special = out_range || (src_ff == dst_ff);
      status.last_row = (u_ff == NW'(MAX_NODES - 1));
      status.row_end = (CW'(u_ff) == eff_n - CW'(1));
      status.round_end = !changed_ff || (round_ff == eff_n - CW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NC_RESET;
         u_ff          <= '0;
         round_ff      <= '0;
         changed_ff    <= 1'b0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
         if (ctrl.u_clr) begin
            u_ff <= '0;
         end else if (ctrl.u_inc) begin
            u_ff <= u_ff + NW'(1);
         end
         if (ctrl.init_q) begin
            round_ff <= '0;
         end else if (ctrl.round_inc) begin
            round_ff <= round_ff + CW'(1);
         end
         if (ctrl.init_q || ctrl.round_inc) begin
            changed_ff <= 1'b0;
         end else if (|upd) begin
            changed_ff <= 1'b1;
         end
         rd_vld_ff    <= ctrl.row_read;
         rsp_valid_ff <= ctrl.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.clr_row) begin
         adj_mem[u_ff] <= '0;
      end else if (wr_ok) begin
         adj_mem[NW'(req_from_node)][NW'(req_to_node)] <= cap_sat;
      end
      row_ff <= adj_mem[u_ff];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         src_ff <= req_from_node;
         dst_ff <= req_to_node;
      end
      if (ctrl.row_read) begin
         bu_ff <= best_rd;
      end
      if (ctrl.emit) begin
         rsp_data_ff <= ctrl.res_special ? special_val : best_rd;
      end
      for (int v = 0; v < MAX_NODES; v++) begin
         if (ctrl.init_q) begin
            best_ff[v] <= (32'(src_ff) == v) ? SAME_NODE_WIDTH : '0;
         end else if (upd[v]) begin
            best_ff[v] <= cand[v];
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bottleneck = rsp_data_ff;

endmodule

@@ sv/wpq_checker.sv @@
// Port-level checker for the widest-path query core, bound to the top level.
// Depends on wpq_pkg and widest_path_query_core_assert.svh.
`include "widest_path_query_core_assert.svh"

module wpq_checker
   import wpq_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             req_opcode,
   input logic             rsp_valid,
   input logic [CAP_W-1:0] rsp_bottleneck
);

   // A result beat never exceeds the same-node marker value.
   `WPQ_ASSERT_IMP(a_rsp_range, clock, reset, rsp_valid, rsp_bottleneck <= SAME_NODE_WIDTH, "bottleneck out of range")
   `WPQ_ASSERT_NXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "result beat repeated")
   `WPQ_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy, "result beat while busy")
   `WPQ_ASSERT_NXT(a_query_busy, clock, reset, start && !busy && req_opcode == OP_QUERY, busy, "query beat did not start work")
   `WPQ_ASSERT_NXT(a_write_free, clock, reset, start && !busy && req_opcode == OP_WRITE, !busy && !rsp_valid, "write beat stalled or answered")

endmodule

bind widest_path_query_core wpq_checker u_wpq_checker (.*);

@@ tb/sv/widest_path_query_core_tb.sv @@
// Self-checking testbench for widest_path_query_core: directed and random edge writes and
// widest-path queries over several node counts, each result checked against a planned width or a local predictor.
// Depends on wpq_pkg and the widest_path_query_core RTL; needs no files or arguments.
module widest_path_query_core_tb
   import wpq_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BEAT_TARGET = 1250;
   localparam int CALM_TAIL   = 150;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_WAIT  = 300;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic              op;
      logic [NODE_W-1:0] src;
      logic [NODE_W-1:0] dst;
      logic [CAP_W-1:0]  value;
      logic              known;
      logic [CAP_W-1:0]  width;
   } plan_row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_opcode;
   logic [NODE_W-1:0] req_from_node;
   logic [NODE_W-1:0] req_to_node;
   logic [CAP_W-1:0]  req_capacity;
   logic              rsp_valid;
   logic [CAP_W-1:0]  rsp_bottleneck;
   logic              csr_wr_en;
   logic [NC_W-1:0]   csr_wr_data;

   logic [CAP_W-1:0]  cap_matrix [MAX_NODES_DEF][MAX_NODES_DEF];
   logic [NC_W-1:0]   node_cfg;
   logic [CAP_W-1:0]  pending_widths [$];
   logic [CAP_W-1:0]  oldest_width;
   plan_row_type      plan [$];
   int                fail_count;
   int                beats_sent;
   int                writes_sent;
   int                queries_sent;
   int                widths_checked;
   int                cfg_settings;
   int                stall_cycles;

   widest_path_query_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_opcode    (req_opcode),
      .req_from_node (req_from_node),
      .req_to_node   (req_to_node),
      .req_capacity  (req_capacity),
      .rsp_valid     (rsp_valid),
      .rsp_bottleneck(rsp_bottleneck),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int nodes_in_use();
      return (node_cfg > MAX_NODES_DEF) ? MAX_NODES_DEF : int'(node_cfg);
   endfunction

   function automatic logic [CAP_W-1:0] widest_bottleneck(input logic [NODE_W-1:0] src,
                                                          input logic [NODE_W-1:0] dst);
      logic [CAP_W-1:0] reach [MAX_NODES_DEF];
      logic [CAP_W-1:0] cand;
      int               n;
      logic             moved;
      n = nodes_in_use();
      if (src >= n || dst >= n) return '0;
      if (src == dst) return SAME_NODE_WIDTH;
      foreach (reach[i]) reach[i] = '0;
      reach[src] = SAME_NODE_WIDTH;
      moved = 1'b1;
      for (int r = 0; r < n && moved; r++) begin
         moved = 1'b0;
         for (int u = 0; u < n; u++) begin
            if (reach[u] != '0) begin
               for (int v = 0; v < n; v++) begin
                  if (cap_matrix[u][v] != '0) begin
                     cand = (cap_matrix[u][v] < reach[u]) ? cap_matrix[u][v] : reach[u];
                     if (cand > reach[v]) begin
                        reach[v] = cand;
                        moved = 1'b1;
                     end
                  end
               end
            end
         end
      end
      return reach[dst];
   endfunction

   function automatic void add_row(input row_kind_type kind, input logic op, input int src,
                                   input int dst, input int value, input logic known,
                                   input int width);
      plan_row_type r;
      r.kind  = kind;
      r.op    = op;
      r.src   = src[NODE_W-1:0];
      r.dst   = dst[NODE_W-1:0];
      r.value = value[CAP_W-1:0];
      r.known = known;
      r.width = width[CAP_W-1:0];
      plan = {plan, r};
   endfunction

   function automatic logic [NODE_W-1:0] pick_node(input int n);
      if (n > 0 && $urandom_range(0, 99) < 85) return NODE_W'($urandom_range(0, n - 1));
      return NODE_W'($urandom_range(0, 15));
   endfunction

   task automatic report_mismatch(input string what, input logic [CAP_W-1:0] want,
                                  input logic [CAP_W-1:0] got);
      $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
      fail_count++;
   endtask

   task automatic send_beat(input logic op, input logic [NODE_W-1:0] src,
                            input logic [NODE_W-1:0] dst, input logic [CAP_W-1:0] value,
                            input logic known, input logic [CAP_W-1:0] width);
      @(negedge clock);
      start         = 1'b1;
      req_opcode    = op;
      req_from_node = src;
      req_to_node   = dst;
      req_capacity  = value;
      do @(posedge clock); while (busy);
      if (op == OP_WRITE) begin
         cap_matrix[src][dst] = (value > CAP_MAX) ? CAP_MAX : value;
         writes_sent++;
      end else begin
         pending_widths = {pending_widths, (known ? width : widest_bottleneck(src, dst))};
         queries_sent++;
      end
      beats_sent++;
   endtask

   task automatic hold_off(input int cycles);
      @(negedge clock);
      start = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic maybe_idle(input int idle_pct);
      if (beats_sent < BEAT_TARGET - CALM_TAIL && $urandom_range(0, 99) < idle_pct)
         hold_off($urandom_range(1, 15));
   endtask

   task automatic set_node_count(input logic [NC_W-1:0] value);
      hold_off(1);
      while (pending_widths.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      node_cfg  = value;
      cfg_settings++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_widths.size() == 0) begin
            report_mismatch("result with no query outstanding", '0, rsp_bottleneck);
         end else begin
            oldest_width = pending_widths.pop_front();
            widths_checked++;
            if (rsp_bottleneck !== oldest_width)
               report_mismatch("bottleneck", oldest_width, rsp_bottleneck);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid === 1'b1) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat accepted for %0d cycles, %0d results outstanding",
                  stall_cycles, pending_widths.size());
         $display("widest_path_query_core verification failed");
         $finish;
      end
   end

   initial begin
      logic [NODE_W-1:0] order [MAX_NODES_DEF];
      logic [NODE_W-1:0] swap;
      logic [NODE_W-1:0] src;
      logic [CAP_W-1:0]  value;
      logic [NC_W-1:0]   cfg_pick;
      int                n;
      int                j;
      int                idle_pct;
      int                phase_len;

      reset         = 1'b1;
      start         = 1'b0;
      req_opcode    = OP_WRITE;
      req_from_node = '0;
      req_to_node   = '0;
      req_capacity  = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      fail_count    = 0;
      beats_sent    = 0;
      writes_sent   = 0;
      queries_sent  = 0;
      widths_checked = 0;
      cfg_settings  = 0;
      stall_cycles  = 0;
      node_cfg      = NC_RESET;
      foreach (cap_matrix[a, b]) cap_matrix[a][b] = '0;

      add_row(ROW_BEAT, OP_QUERY, 0, 5, 0, 1'b1, 0);
      add_row(ROW_BEAT, OP_QUERY, 3, 3, 0, 1'b1, SAME_NODE_WIDTH);
      add_row(ROW_BEAT, OP_QUERY, 15, 15, 'h1FFFF, 1'b1, SAME_NODE_WIDTH);
      add_row(ROW_BEAT, OP_WRITE, 0, 1, 'h1FFFF, 1'b0, 0);
      add_row(ROW_BEAT, OP_QUERY, 0, 1, 0, 1'b1, CAP_MAX);
      add_row(ROW_BEAT, OP_WRITE, 1, 2, 1, 1'b0, 0);
      add_row(ROW_BEAT, OP_QUERY, 0, 2, 0, 1'b1, 1);
      add_row(ROW_BEAT, OP_WRITE, 15, 0, 50000, 1'b0, 0);
      add_row(ROW_BEAT, OP_QUERY, 15, 2, 0, 1'b1, 1);
      add_row(ROW_BEAT, OP_QUERY, 15, 1, 0, 1'b1, 50000);
      add_row(ROW_BEAT, OP_QUERY, 2, 0, 0, 1'b1, 0);
      add_row(ROW_BEAT, OP_WRITE, 1, 2, 0, 1'b0, 0);
      add_row(ROW_BEAT, OP_QUERY, 0, 2, 0, 1'b1, 0);
      add_row(ROW_BEAT, OP_WRITE, 0, 15, CAP_MAX, 1'b0, 0);
      add_row(ROW_BEAT, OP_WRITE, 15, 14, 99999, 1'b0, 0);
      add_row(ROW_BEAT, OP_WRITE, 0, 14, 5, 1'b0, 0);
      add_row(ROW_BEAT, OP_QUERY, 0, 14, 0, 1'b0, 0);
      add_row(ROW_CSR, OP_WRITE, 0, 0, 0, 1'b0, 0);
      add_row(ROW_BEAT, OP_QUERY, 0, 0, 0, 1'b1, 0);
      add_row(ROW_CSR, OP_WRITE, 0, 0, 1, 1'b0, 0);
      add_row(ROW_BEAT, OP_QUERY, 0, 0, 0, 1'b1, SAME_NODE_WIDTH);
      add_row(ROW_BEAT, OP_QUERY, 0, 1, 0, 1'b1, 0);
      add_row(ROW_CSR, OP_WRITE, 0, 0, 15, 1'b0, 0);
      add_row(ROW_BEAT, OP_QUERY, 15, 15, 0, 1'b1, 0);
      add_row(ROW_BEAT, OP_QUERY, 0, 1, 0, 1'b1, CAP_MAX);
      add_row(ROW_BEAT, OP_WRITE, 14, 13, 12345, 1'b0, 0);
      add_row(ROW_CSR, OP_WRITE, 0, 0, 31, 1'b0, 0);
      add_row(ROW_BEAT, OP_QUERY, 15, 13, 0, 1'b0, 0);
      add_row(ROW_BEAT, OP_QUERY, 15, 14, 0, 1'b0, 0);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            set_node_count(plan[i].value[NC_W-1:0]);
         end else begin
            send_beat(plan[i].op, plan[i].src, plan[i].dst, plan[i].value, plan[i].known,
                      plan[i].width);
         end
      end

      while (beats_sent < BEAT_TARGET) begin
         case ($urandom_range(0, 9))
            0: cfg_pick = 5'd0;
            1: cfg_pick = 5'd1;
            2, 3: cfg_pick = 5'd16;
            4: cfg_pick = NC_W'($urandom_range(17, 31));
            default: cfg_pick = NC_W'($urandom_range(2, 15));
         endcase
         set_node_count(cfg_pick);
         n = nodes_in_use();
         case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 20;
            default: idle_pct = 50;
         endcase

         // A chain through a shuffled node order forces many relaxation rounds.
         if (n > 1 && $urandom_range(0, 1) == 1) begin
            for (int i = 0; i < MAX_NODES_DEF; i++) order[i] = NODE_W'(i);
            for (int i = n - 1; i > 0; i--) begin
               j = $urandom_range(0, i);
               swap = order[i];
               order[i] = order[j];
               order[j] = swap;
            end
            for (int k = 0; k < n - 1; k++) begin
               maybe_idle(idle_pct);
               send_beat(OP_WRITE, order[k], order[k + 1], CAP_W'($urandom_range(1, CAP_MAX)),
                         1'b0, '0);
            end
         end

         phase_len = $urandom_range(30, 80);
         for (int k = 0; k < phase_len && beats_sent < BEAT_TARGET; k++) begin
            maybe_idle(idle_pct);
            if ($urandom_range(0, 99) < 40) begin
               src = pick_node(n);
               send_beat(OP_QUERY, src, ($urandom_range(0, 9) == 0) ? src : pick_node(n),
                         CAP_W'($urandom_range(0, 'h1FFFF)), 1'b0, '0);
            end else begin
               case ($urandom_range(0, 19))
                  0, 1, 2, 3, 4, 5, 6: value = '0;
                  7, 8: value = CAP_MAX;
                  9, 10: value = CAP_W'($urandom_range(CAP_MAX + 1, 'h1FFFF));
                  11, 12: value = CAP_W'($urandom_range(1, 8));
                  default: value = CAP_W'($urandom_range(1, CAP_MAX));
               endcase
               send_beat(OP_WRITE, pick_node(n), pick_node(n), value, 1'b0, '0);
            end
         end
      end

      hold_off(1);
      while (pending_widths.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d beats: %0d edge writes and %0d widest-path queries across %0d node counts.",
               beats_sent, writes_sent, queries_sent, cfg_settings);
      $display("Checked %0d bottleneck results, %0d mismatches.", widths_checked, fail_count);
      if (fail_count == 0) begin
         $display("widest_path_query_core verification clean");
      end else begin
         $display("widest_path_query_core verification failed");
      end
      $finish;
   end

endmodule
